>>> hw/rtl/pset_pkg.sv
`timescale 1ns / 1ps

package pset_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int SYM_W    = 10;
  localparam int TIME_W   = 63;
  localparam int PRICE_W  = 32;
  localparam int CNT_W    = 32;
  localparam int THR_W    = 16;
  localparam int STATUS_W = 2;

  // Symbol table depth default
  localparam int SYMBOL_COUNT_DEF = 1024;

  // Basis-point scale of the jump test
  localparam int SCALE_W   = 14;
  localparam int BPS_SCALE = 10000;

  // Configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic REG_ALERTS_EN = 1'b0;
  localparam logic REG_JUMP_THR  = 1'b1;

  localparam logic             ALERTS_EN_RST = 1'b1;
  localparam logic [THR_W-1:0] JUMP_THR_RST  = THR_W'(100);

  // Event types
  localparam logic [CMD_W-1:0] CMD_PRICE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEW    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_PARSE_ERR    = 2'd0,
    ST_OUT_OF_ORDER = 2'd1,
    ST_UNKNOWN      = 2'd2,
    ST_ACCEPTED     = 2'd3
  } status_t;

  typedef struct packed {
    logic             alerts_en;
    logic [THR_W-1:0] jump_thr;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  last_time;
    logic [PRICE_W-1:0] held_price;
    logic               price_seen;
    logic [CNT_W-1:0]   upd_cnt;
    logic [CNT_W-1:0]   new_cnt;
    logic [CNT_W-1:0]   fill_cnt;
    logic [CNT_W-1:0]   cancel_cnt;
  } entry_t;

endpackage

>>> hw/rtl/per_symbol_event_tracker_core.sv
`timescale 1ns / 1ps

// Per-symbol market event tracker. Each request carries one event (type, symbol,
// timestamp, price) and yields exactly one result with a status, an optional price
// jump alert, the symbol's updated counter for that event type and the four
// saturating global counters. All per-symbol state sits in one table memory of
// SYMBOL_COUNT entries with a registered read; an event is handled one at a time as
// reduce index, read, modify and write back, compare, and no request is taken until
// the last result is in the output register, which waits on out_ready. The spacing
// is set by the read-modify-write of the single table plus the registered multiply
// ahead of the jump compare. After reset the block sweeps the table to zero, one
// entry per cycle, and takes no request until all SYMBOL_COUNT entries (1024 by
// default) are cleared; configuration writes are taken meanwhile. The jump test is
// |new - prev| * 10000 >= threshold * prev, exact in integers.
module per_symbol_event_tracker_core #(
  parameter int SYMBOL_COUNT = pset_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // event requests
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pset_pkg::CMD_W-1:0]         in_command,
  input  logic                               in_symbol_valid,
  input  logic [pset_pkg::SYM_W-1:0]         in_symbol_id,
  input  logic [pset_pkg::TIME_W-1:0]        in_event_time,
  input  logic [pset_pkg::PRICE_W-1:0]       in_price,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pset_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_alert,
  output logic [pset_pkg::PRICE_W-1:0]       out_previous_price,
  output logic [pset_pkg::CNT_W-1:0]         out_symbol_event_count,
  output logic [pset_pkg::CNT_W-1:0]         out_total_seen,
  output logic [pset_pkg::CNT_W-1:0]         out_parsed_seen,
  output logic [pset_pkg::CNT_W-1:0]         out_malformed_seen,
  output logic [pset_pkg::CNT_W-1:0]         out_rejected_seen,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pset_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pset_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pset_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import pset_pkg::*;

  localparam int IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  // symbol_id mod SYMBOL_COUNT by reciprocal: q = (id * floor(2^RSH / N)) >> RSH
  // is the true quotient or one less, so one compare-subtract finishes it.
  localparam int RSH      = 2 * SYM_W;
  localparam int RECIP    = (1 << RSH) / SYMBOL_COUNT;
  localparam int QPROD_W  = RSH + SYM_W;
  localparam int QN_W     = 32;
  localparam int LHS_W    = PRICE_W + SCALE_W;
  localparam int RHS_W    = THR_W + PRICE_W;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_IDX,
    S_RD,
    S_CALC,
    S_CMP
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

  cfg_t cfg;

  pset_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state_r, state_nxt;

  // captured request
  logic [CMD_W-1:0]   cmd_r;
  logic               sym_valid_r;
  logic [SYM_W-1:0]   sym_r;
  logic [TIME_W-1:0]  time_r;
  logic [PRICE_W-1:0] price_r;
  logic [SYM_W-1:0]   q_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   clr_idx_r;

  // table memory
  entry_t mem_r [SYMBOL_COUNT];
  entry_t rdata_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  // calc results
  status_t            status_r;
  logic [CNT_W-1:0]   count_r;
  logic               cand_r;
  logic [LHS_W-1:0]   lhs_r;
  logic [RHS_W-1:0]   rhs_r;
  logic [PRICE_W-1:0] prev_r;

  // global counters
  logic [CNT_W-1:0] total_r, parsed_r, malformed_r, rejected_r;

  // output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_alert_r;
  logic [PRICE_W-1:0] out_prev_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [CNT_W-1:0]   out_total_r, out_parsed_r, out_malformed_r, out_rejected_r;

  // ---------------------------------------------------------------------------
  // Index reduction
  // ---------------------------------------------------------------------------
  logic [QPROD_W-1:0] q_prod;
  logic [QN_W-1:0]    qn;
  logic [QN_W-1:0]    r_wide;
  logic [SYM_W-1:0]   r_raw;
  logic [SYM_W-1:0]   r_fix;

  assign q_prod = QPROD_W'(in_symbol_id) * QPROD_W'(RECIP);
  assign qn     = QN_W'(q_r) * QN_W'(SYMBOL_COUNT);
  assign r_wide = QN_W'(sym_r) - qn;
  assign r_raw  = r_wide[SYM_W-1:0];
  // take off one more modulus when the quotient came out one low
  assign r_fix  = (QN_W'(r_raw) >= QN_W'(SYMBOL_COUNT)) ?
                  SYM_W'(QN_W'(r_raw) - QN_W'(SYMBOL_COUNT)) : r_raw;

  // ---------------------------------------------------------------------------
  // Entry update, evaluated while the read data of this event is in rdata_r
  // ---------------------------------------------------------------------------
  logic               malformed;
  logic               late;
  logic               known;
  logic               take;
  entry_t             upd_entry;
  logic [CNT_W-1:0]   new_count;
  logic [PRICE_W-1:0] diff;
  logic               cand;
  status_t            status_c;

  assign malformed = !sym_valid_r || (time_r == '0);
  // a zero stored time never rejects since the new time is never below zero
  assign late      = time_r < rdata_r.last_time;
  assign take      = !malformed && !late;
  assign diff      = (price_r >= rdata_r.held_price) ? price_r - rdata_r.held_price
                                                      : rdata_r.held_price - price_r;

  always_comb begin
    upd_entry = rdata_r;
    new_count = '0;
    known     = 1'b1;
    upd_entry.last_time = time_r;
    case (cmd_r)
      CMD_PRICE: begin
        new_count            = rdata_r.upd_cnt + CNT_W'(1);
        upd_entry.upd_cnt    = new_count;
        upd_entry.held_price = price_r;
        upd_entry.price_seen = 1'b1;
      end
      CMD_NEW: begin
        new_count         = rdata_r.new_cnt + CNT_W'(1);
        upd_entry.new_cnt = new_count;
      end
      CMD_FILL: begin
        new_count          = rdata_r.fill_cnt + CNT_W'(1);
        upd_entry.fill_cnt = new_count;
      end
      CMD_CANCEL: begin
        new_count            = rdata_r.cancel_cnt + CNT_W'(1);
        upd_entry.cancel_cnt = new_count;
      end
      default: begin
        // unknown type: keep only the timestamp
        known = 1'b0;
      end
    endcase
  end

  assign cand = take && (cmd_r == CMD_PRICE) && rdata_r.price_seen && cfg.alerts_en &&
                (rdata_r.held_price != '0);

  always_comb begin
    if (malformed) begin
      status_c = ST_PARSE_ERR;
    end else if (late) begin
      status_c = ST_OUT_OF_ORDER;
    end else if (!known) begin
      status_c = ST_UNKNOWN;
    end else begin
      status_c = ST_ACCEPTED;
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory: clear sweep after reset, write-back of the modified entry
  // ---------------------------------------------------------------------------
  assign mem_we    = (state_r == S_CLR) || ((state_r == S_CALC) && take);
  assign mem_waddr = (state_r == S_CLR) ? clr_idx_r : idx_r;
  assign mem_wdata = (state_r == S_CLR) ? entry_t'('0) : upd_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      rdata_r <= mem_r[idx_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_idx_r == IDX_W'(SYMBOL_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_IDX;
      S_IDX:  state_nxt = S_RD;
      S_RD:   state_nxt = S_CALC;
      S_CALC: state_nxt = S_CMP;
      S_CMP:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      parsed_r    <= '0;
      malformed_r <= '0;
      rejected_r  <= '0;
    end else begin
      state_r <= state_nxt;
      // drop the result once taken, unless a new one loads in this cycle
      if (out_valid_r && out_ready && (state_r != S_CMP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r       <= in_command;
            sym_valid_r <= in_symbol_valid;
            sym_r       <= in_symbol_id;
            time_r      <= in_event_time;
            price_r     <= in_price;
            q_r         <= q_prod[RSH +: SYM_W];
          end
        end
        S_IDX: begin
          idx_r <= IDX_W'(r_fix);
        end
        S_RD: begin
          // memory read in flight
        end
        S_CALC: begin
          status_r <= status_c;
          count_r  <= (take && known) ? new_count : '0;
          cand_r   <= cand;
          prev_r   <= rdata_r.held_price;
          lhs_r    <= LHS_W'(diff) * LHS_W'(BPS_SCALE);
          rhs_r    <= RHS_W'(cfg.jump_thr) * RHS_W'(rdata_r.held_price);
          total_r  <= sat_inc(total_r);
          if (malformed) begin
            malformed_r <= sat_inc(malformed_r);
          end else begin
            parsed_r <= sat_inc(parsed_r);
            if (late || !known) begin
              rejected_r <= sat_inc(rejected_r);
            end
          end
        end
        S_CMP: begin
          // hold here until the output register is free
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_status_r    <= status_r;
            out_alert_r     <= cand_r && (RHS_W'(lhs_r) >= rhs_r);
            out_prev_r      <= (cand_r && (RHS_W'(lhs_r) >= rhs_r)) ? prev_r : '0;
            out_count_r     <= count_r;
            out_total_r     <= total_r;
            out_parsed_r    <= parsed_r;
            out_malformed_r <= malformed_r;
            out_rejected_r  <= rejected_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_alert              = out_alert_r;
  assign out_previous_price     = out_prev_r;
  assign out_symbol_event_count = out_count_r;
  assign out_total_seen         = out_total_r;
  assign out_parsed_seen        = out_parsed_r;
  assign out_malformed_seen     = out_malformed_r;
  assign out_rejected_seen      = out_rejected_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (32'(idx_r) < 32'(SYMBOL_COUNT)))
    else $error("reduced symbol index beyond table depth");

  a_alert_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_alert_r) |-> ((out_status_r == ST_ACCEPTED) && (out_prev_r != '0)))
    else $error("alert on a non-accepted event or with zero previous price");

  a_total_split: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '1) |-> ((CNT_W + 1)'(total_r) ==
                          (CNT_W + 1)'(parsed_r) + (CNT_W + 1)'(malformed_r)))
    else $error("total count differs from parsed plus malformed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ((state_r == S_IDX) && !in_ready))
    else $error("request accepted while another is in flight");

endmodule

>>> hw/rtl/pset_cfg.sv
`timescale 1ns / 1ps

module pset_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pset_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [pset_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [pset_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output pset_pkg::cfg_t                       cfg
);
  import pset_pkg::*;

  logic             alerts_en_r;
  logic [THR_W-1:0] jump_thr_r;
  logic             reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alerts_en_r <= ALERTS_EN_RST;
      jump_thr_r  <= JUMP_THR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALERTS_EN: alerts_en_r <= pwdata[0];
        REG_JUMP_THR:  jump_thr_r  <= pwdata[THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALERTS_EN: prdata = CFG_DATA_W'(alerts_en_r);
      REG_JUMP_THR:  prdata = CFG_DATA_W'(jump_thr_r);
    endcase
  end

  assign cfg.alerts_en = alerts_en_r;
  assign cfg.jump_thr  = jump_thr_r;

endmodule
